// ===== rtl/sita_pkg.sv =====
// shared types, constants and codes of the sorted id table allocator
package sita_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = 8;
  localparam int CNT_W    = 9;
  localparam int NUM_IDS  = 256;
  localparam int GRP_SZ   = 16;
  localparam int NUM_GRP  = NUM_IDS / GRP_SZ;
  localparam int GRP_W    = $clog2(GRP_SZ);

  // commands
  localparam logic [2:0] CMD_INS_AUTO = 3'd0;
  localparam logic [2:0] CMD_INS_AT   = 3'd1;
  localparam logic [2:0] CMD_REMOVE   = 3'd2;
  localparam logic [2:0] CMD_LOOKUP   = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;
  localparam logic [2:0] CMD_QUERY    = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  // cell operations
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_RM   = 2'd2;
  localparam logic [1:0] CELL_CLR  = 2'd3;

  typedef struct packed {
    logic [2:0]      command;
    logic [ID_W-1:0] item_id;
    logic [ID_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ID_W-1:0]  result_id;
    logic             present;
    logic [CNT_W-1:0] item_count;
    logic [ID_W-1:0]  next_free;
  } rsp_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== rtl/sita_cell.sv =====
// one slot of the sorted id chain, shifts toward either neighbor
module sita_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sita_pkg::cell_ctrl_t ctrl,
  input  sita_pkg::entry_t    prev_ent,
  input  logic                prev_place,
  input  sita_pkg::entry_t    next_ent,
  output sita_pkg::entry_t    ent,
  output logic                place
);
  import sita_pkg::*;

  logic            valid_r, valid_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic            rm;

  // new key belongs here or earlier
  assign place = !valid_r || (id_r > ctrl.key);
  // removed key sits here or earlier
  assign rm    = valid_r && (id_r >= ctrl.key);

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    unique case (ctrl.op)
      CELL_HOLD: ;
      CELL_INS: begin
        if (prev_place) begin
          valid_nxt = prev_ent.valid;
          id_nxt    = prev_ent.id;
        end else if (place) begin
          valid_nxt = 1'b1;
          id_nxt    = ctrl.key;
        end
      end
      CELL_RM: begin
        if (rm) begin
          valid_nxt = next_ent.valid;
          id_nxt    = next_ent.id;
        end
      end
      CELL_CLR: valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign ent.valid = valid_r;
  assign ent.id    = id_r;

endmodule

// ===== rtl/sita_free_search.sv =====
// lowest clear bit of the occupancy map, group stage registered
module sita_free_search (
  input  logic                          clk,
  input  logic [sita_pkg::NUM_IDS-1:0]  occ,
  output logic                          any_free,
  output logic [sita_pkg::ID_W-1:0]     low_free
);
  import sita_pkg::*;

  logic [NUM_GRP-1:0] grp_any_r, grp_any_nxt;
  logic [GRP_W-1:0]   grp_low_r [NUM_GRP];
  logic [GRP_W-1:0]   grp_low_nxt [NUM_GRP];

  // per group priority encode
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_low_nxt[g] = '0;
      for (int b = GRP_SZ - 1; b >= 0; b--) begin
        if (!occ[g*GRP_SZ + b]) begin
          grp_any_nxt[g] = 1'b1;
          grp_low_nxt[g] = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_low_r[g] <= grp_low_nxt[g];
    end
  end

  // priority over groups
  always_comb begin
    any_free = 1'b0;
    low_free = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        any_free = 1'b1;
        low_free = {(ID_W - GRP_W)'(g), grp_low_r[g]};
      end
    end
  end

endmodule

// ===== rtl/sorted_id_table_allocator_unit.sv =====
// top level of the sorted id table allocator: decode, cell chain, free id search
// an accepted request is decoded and applied to the table; its result is published from S_DONE
// once the free id group stage settles; no request is taken until that result is published
// a result waiting on out_stall does not block the next request; the search waits for the slot
// reset (rst_n low, synchronous) empties the table: occupancy and cell valid bits clear,
// count and lowest free id zero; no clearing pass is needed
module sorted_id_table_allocator_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sita_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sita_pkg::rsp_t out_data
);
  import sita_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [NUM_IDS-1:0] occ_r;
  logic [CNT_W-1:0]   count_r;
  logic [ID_W-1:0]    lowest_free_r;

  // per-request fields held until the search finishes
  logic [2:0]         pend_st_r;
  logic [ID_W-1:0]    pend_rid_r;
  logic               pend_pres_r;

  logic               out_valid_r;
  rsp_t               out_r;

  logic               in_take;
  logic               out_free;
  logic               full;
  logic               id_used;
  logic               auto_used;

  // decode results
  logic [2:0]         dec_st;
  logic [ID_W-1:0]    dec_rid;
  logic               dec_pres;
  logic               dec_ins;
  logic               dec_rm;
  logic               dec_clr;
  logic [ID_W-1:0]    dec_key;

  cell_ctrl_t         cell_ctrl;
  entry_t             ent [CAPACITY];
  logic [CAPACITY-1:0] place;
  logic [CAPACITY-1:0] cell_valid;
  logic [ID_W-1:0]    lk_id;

  logic               any_free;
  logic [ID_W-1:0]    low_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  // output slot is empty or is being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign full      = (count_r >= CNT_W'(CAPACITY));
  assign id_used   = occ_r[in_data.item_id];
  assign auto_used = occ_r[lowest_free_r];

  // lookup: select the cell at the requested position
  always_comb begin
    lk_id = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (ID_W'(k) == in_data.position) begin
        lk_id = lk_id | ent[k].id;
      end
    end
  end

  // command decode against the current table
  always_comb begin
    dec_st   = ST_OK;
    dec_rid  = '0;
    dec_pres = 1'b0;
    dec_ins  = 1'b0;
    dec_rm   = 1'b0;
    dec_clr  = 1'b0;
    dec_key  = in_data.item_id;
    unique case (in_data.command)
      CMD_INS_AUTO: begin
        dec_key = lowest_free_r;
        if (full) begin
          dec_st = ST_FULL;
        end else if (auto_used) begin
          dec_st = ST_EXISTS;
        end else begin
          dec_ins = 1'b1;
          dec_rid = lowest_free_r;
        end
      end
      CMD_INS_AT: begin
        if (full) begin
          dec_st = ST_FULL;
        end else if (id_used) begin
          dec_st = ST_EXISTS;
        end else begin
          dec_ins = 1'b1;
          dec_rid = in_data.item_id;
        end
      end
      CMD_REMOVE: begin
        if (!id_used) begin
          dec_st = ST_NOT_FOUND;
        end else begin
          dec_rm = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (({1'b0, in_data.position} >= count_r) ||
            ({1'b0, in_data.position} >= CNT_W'(CAPACITY))) begin
          dec_st = ST_RANGE;
        end else begin
          dec_rid = lk_id;
        end
      end
      CMD_CLEAR: dec_clr = 1'b1;
      CMD_QUERY: dec_pres = id_used;
      default: ;
    endcase
  end

  // chain control, only on an accepted request
  always_comb begin
    cell_ctrl.key = dec_key;
    cell_ctrl.op  = CELL_HOLD;
    if (in_take) begin
      priority if (dec_clr) begin
        cell_ctrl.op = CELL_CLR;
      end else if (dec_ins) begin
        cell_ctrl.op = CELL_INS;
      end else if (dec_rm) begin
        cell_ctrl.op = CELL_RM;
      end
    end
  end

  // chain of sorted id cells; cell 0 holds the smallest id
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_place;

    if (k == 0) begin : g_first
      assign prev_ent   = '0;
      assign prev_place = 1'b0;
    end else begin : g_mid
      assign prev_ent   = ent[k-1];
      assign prev_place = place[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[k+1];
    end

    sita_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .prev_ent   (prev_ent),
      .prev_place (prev_place),
      .next_ent   (next_ent),
      .ent        (ent[k]),
      .place      (place[k])
    );

    assign cell_valid[k] = ent[k].valid;
  end

  // lowest free id from the occupancy map, one registered group stage
  sita_free_search u_free (
    .clk      (clk),
    .occ      (occ_r),
    .any_free (any_free),
    .low_free (low_free)
  );

  // sequencer: accept, let the group stage settle, then publish
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_take) state_nxt = S_SRCH;
      S_SRCH: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      occ_r         <= '0;
      count_r       <= '0;
      lowest_free_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take) begin
        priority if (dec_clr) begin
          occ_r         <= '0;
          count_r       <= '0;
          lowest_free_r <= '0;
        end else if (dec_ins) begin
          occ_r[dec_key] <= 1'b1;
          count_r        <= count_r + CNT_W'(1);
        end else if (dec_rm) begin
          occ_r[dec_key] <= 1'b0;
          count_r        <= count_r - CNT_W'(1);
        end
      end
      // keep the old value when every id is taken
      if (state_r == S_DONE && out_free && any_free) begin
        lowest_free_r <= low_free;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request-held fields and the result register
  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_st_r   <= dec_st;
      pend_rid_r  <= dec_rid;
      pend_pres_r <= dec_pres;
    end
    if (state_r == S_DONE && out_free) begin
      out_r.status     <= pend_st_r;
      out_r.result_id  <= pend_rid_r;
      out_r.present    <= pend_pres_r;
      out_r.item_count <= count_r;
      out_r.next_free  <= any_free ? low_free : lowest_free_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_chain_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == count_r)
    else $error("cell chain out of step with count");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_r) == count_r)
    else $error("occupancy out of step with count");

  a_free_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (count_r < CNT_W'(NUM_IDS)) |-> !occ_r[lowest_free_r])
    else $error("lowest free id is in use");

  a_take_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_SRCH))
    else $error("accepted request did not start search");

endmodule
